[rtl/core/input_frame_packet_validator_core_assert.svh]
// Assertion macros for the input frame packet validator
`ifndef INPUT_FRAME_PACKET_VALIDATOR_CORE_ASSERT_SVH
`define INPUT_FRAME_PACKET_VALIDATOR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define IFPV_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define IFPV_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define IFPV_ASSERT_IMPL(label, clk, rst_n, prop)
`define IFPV_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

[rtl/core/ifpv_pkg.sv]
// Shared types, constants and functions of the input frame packet validator
package ifpv_pkg;
    localparam int unsigned MaxPacketBytes = 65536;
    localparam int unsigned MaxRoomBytes   = 16;
    localparam int unsigned QueueDepth     = 4;
    localparam logic [31:0] PktMagic  = 32'h5043_5358;
    localparam logic [31:0] CrcPoly   = 32'hEDB8_8320;
    localparam logic [31:0] CrcOnes   = 32'hFFFF_FFFF;
    localparam logic [15:0] TypeInput = 16'h0001;
    localparam int unsigned HdrBytes  = 16;

    localparam logic [3:0] ST_OK      = 4'd0;
    localparam logic [3:0] ST_SHORT   = 4'd1;
    localparam logic [3:0] ST_MAGIC   = 4'd2;
    localparam logic [3:0] ST_LENGTHS = 4'd3;
    localparam logic [3:0] ST_VERSION = 4'd4;
    localparam logic [3:0] ST_ROOM    = 4'd5;
    localparam logic [3:0] ST_CRC     = 4'd6;
    localparam logic [3:0] ST_NOTIN   = 4'd7;
    localparam logic [3:0] ST_TRUNC   = 4'd8;

    localparam logic [1:0] REG_VERSION = 2'd0;
    localparam logic [1:0] REG_ROOMLEN = 2'd1;
    localparam logic [1:0] REG_ROOMLO  = 2'd2;
    localparam logic [1:0] REG_ROOMHI  = 2'd3;

    typedef struct packed {
        logic        item_kind;
        logic [63:0] frame_number;
        logic [15:0] sample_index;
        logic [7:0]  pressed;
        logic [7:0]  range_byte;
        logic [7:0]  sample_count;
        logic [3:0]  status;
        logic        last;
    } t_result;

    // Item event from the front part: up to one sample and one verdict
    typedef struct packed {
        logic    has_sample;
        logic    has_verdict;
        t_result sample;
        t_result verdict;
    } t_event;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            x = (x >> 1) ^ (x[0] ? CrcPoly : 32'd0);
        end
        return x;
    endfunction
endpackage

[rtl/core/ifpv_if.sv]
// Valid/ready channel interfaces for input bytes and result items
interface ifpv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ifpv_out_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [63:0] frame_number;
    logic [15:0] sample_index;
    logic [7:0]  pressed;
    logic [7:0]  range_byte;
    logic [7:0]  sample_count;
    logic [3:0]  status;
    logic        last;
    modport source (output valid, output item_kind, output frame_number,
                    output sample_index, output pressed, output range_byte,
                    output sample_count, output status, output last, input ready);
    modport sink (input valid, input item_kind, input frame_number,
                  input sample_index, input pressed, input range_byte,
                  input sample_count, input status, input last, output ready);
endinterface

[rtl/core/input_frame_packet_validator_core.sv]
// Top level of the input frame packet validator
//  channel  | dir | handshake      | payload
//  in_ch    | in  | valid/ready    | data_byte, last_byte
//  out_ch   | out | valid/ready    | sample or verdict result item
//  apb      | in  | psel/penable   | four config registers at 8*i
// One byte per cycle while the queue has room; the CRC and field updates are combinational.
// Events pass through a four-entry queue; a byte carrying both a sample and a
// verdict gives two output items, sample first. Input stalls only when the queue is full.
// Reset is synchronous; it clears the control state and sets the config registers to defaults.
module input_frame_packet_validator_core #(
    parameter int unsigned MAX_PACKET_BYTES = ifpv_pkg::MaxPacketBytes,
    parameter int unsigned MAX_ROOM_BYTES   = ifpv_pkg::MaxRoomBytes
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ifpv_in_if.sink     in_ch,
    ifpv_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    logic [15:0]  r_ver;
    logic [4:0]   r_rlen;
    logic [63:0]  r_lo, r_hi;
    logic         space, ev_valid, acc;
    ifpv_pkg::t_event ev;
    ifpv_pkg::t_result res;

    assign pready = 1'b1;
    assign in_ch.ready = space;
    assign acc = in_ch.valid && space;

    // Write config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ver <= '0; r_rlen <= 5'd3; r_lo <= 64'd5128524; r_hi <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2:0] == 3'd0) begin
                unique case (paddr[4:3])
                    ifpv_pkg::REG_VERSION: r_ver <= pwdata[15:0];
                    ifpv_pkg::REG_ROOMLEN: r_rlen <= pwdata[4:0];
                    ifpv_pkg::REG_ROOMLO:  r_lo <= pwdata;
                    ifpv_pkg::REG_ROOMHI:  r_hi <= pwdata;
                    default: ;
                endcase
            end
        end
    end

    // Read back config registers
    always_comb begin
        unique case (paddr[4:3])
            ifpv_pkg::REG_VERSION: prdata = {48'd0, r_ver};
            ifpv_pkg::REG_ROOMLEN: prdata = {59'd0, r_rlen};
            ifpv_pkg::REG_ROOMLO:  prdata = r_lo;
            ifpv_pkg::REG_ROOMHI:  prdata = r_hi;
            default: prdata = '0;
        endcase
    end

    ifpv_front #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES), .MAX_ROOM_BYTES(MAX_ROOM_BYTES)) u_front (
        .i_clk, .i_rst_n, .i_valid(acc), .i_data_byte(in_ch.data_byte),
        .i_last_byte(in_ch.last_byte), .i_protocol_version(r_ver),
        .i_room_length(r_rlen), .i_room_bytes({r_hi, r_lo}),
        .o_event(ev), .o_event_valid(ev_valid)
    );

    ifpv_back #(.DEPTH(ifpv_pkg::QueueDepth)) u_back (
        .i_clk, .i_rst_n, .i_event_valid(ev_valid), .i_event(ev), .o_space(space),
        .o_result(res), .o_valid(out_ch.valid), .i_ready(out_ch.ready)
    );

    assign out_ch.item_kind = res.item_kind;
    assign out_ch.frame_number = res.frame_number;
    assign out_ch.sample_index = res.sample_index;
    assign out_ch.pressed = res.pressed;
    assign out_ch.range_byte = res.range_byte;
    assign out_ch.sample_count = res.sample_count;
    assign out_ch.status = res.status;
    assign out_ch.last = res.last;

`include "input_frame_packet_validator_core_assert.svh"
    `IFPV_ASSERT_IMPL(a_ready_out, i_clk, i_rst_n, (ev_valid |-> space))
    `IFPV_ASSERT_NEVER(a_pready, i_clk, i_rst_n, !pready)
    `IFPV_ASSERT_IMPL(a_verdict_last, i_clk, i_rst_n, (out_ch.valid && out_ch.item_kind) |-> out_ch.last)
endmodule

[rtl/core/ifpv_front.sv]
// Front part: parses bytes, checks header, room and CRC, builds events
module ifpv_front #(
    parameter int unsigned MAX_PACKET_BYTES = ifpv_pkg::MaxPacketBytes,
    parameter int unsigned MAX_ROOM_BYTES   = ifpv_pkg::MaxRoomBytes
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_byte,
    input  logic [15:0]         i_protocol_version,
    input  logic [4:0]          i_room_length,
    input  logic [127:0]        i_room_bytes,
    output ifpv_pkg::t_event    o_event,
    output logic                o_event_valid
);
    localparam int unsigned PW = $clog2(MAX_PACKET_BYTES + 1);

    logic [PW-1:0] r_pos;
    logic [31:0]   r_hdr, r_exp_crc, r_crc, r_hold;
    logic [15:0]   r_type, r_ver, r_rlen, r_plen;
    logic          r_room_ok, r_magic_ok;
    logic [63:0]   r_frame;
    logic [7:0]    r_decl, r_done;
    logic [2:0]    r_sbp;

    logic [PW-1:0] n_pos;
    logic [31:0]   n_hdr, n_exp_crc, n_crc, n_hold;
    logic [15:0]   n_type, n_ver, n_rlen, n_plen;
    logic          n_room_ok, n_magic_ok;
    logic [63:0]   n_frame;
    logic [7:0]    n_decl, n_done;
    logic [2:0]    n_sbp;

    logic [17:0] pos_w, r_off, pre_len, q_off, inner, need;
    logic        in_range, emit_sample;
    logic [3:0]  st;
    logic [7:0]  cfg_byte;

    assign pos_w    = 18'(r_pos);
    assign in_range = pos_w < 18'(MAX_PACKET_BYTES);
    assign r_off    = pos_w - 18'(ifpv_pkg::HdrBytes);
    assign pre_len  = 18'(ifpv_pkg::HdrBytes) + 18'(r_rlen) + 18'(r_plen);
    assign q_off    = r_off - 18'(r_rlen) - 18'(r_plen);
    assign cfg_byte = i_room_bytes[r_off[3:0]*8 +: 8];

    // Advance the per-byte parse state
    always_comb begin
        n_pos = r_pos; n_hdr = r_hdr; n_exp_crc = r_exp_crc; n_crc = r_crc;
        n_hold = r_hold; n_type = r_type; n_ver = r_ver; n_rlen = r_rlen;
        n_plen = r_plen; n_room_ok = r_room_ok; n_magic_ok = r_magic_ok;
        n_frame = r_frame; n_decl = r_decl; n_done = r_done; n_sbp = r_sbp;
        emit_sample = 1'b0;
        if (in_range) begin
            if (pos_w < 18'(ifpv_pkg::HdrBytes)) begin
                n_hdr = {r_hdr[23:0], i_data_byte};
                unique case (pos_w[3:0])
                    4'd3:  n_magic_ok = (n_hdr == ifpv_pkg::PktMagic);
                    4'd5:  n_ver = n_hdr[15:0];
                    4'd7:  n_type = n_hdr[15:0];
                    4'd9:  n_rlen = n_hdr[15:0];
                    4'd11: n_plen = n_hdr[15:0];
                    4'd15: n_exp_crc = n_hdr;
                    default: ;
                endcase
            end else if (r_off < 18'(r_rlen)) begin
                if (!(r_off < 18'(i_room_length) && r_off < 18'(MAX_ROOM_BYTES)
                      && i_data_byte == cfg_byte))
                    n_room_ok = 1'b0;
            end else if (r_off >= 18'(r_rlen) + 18'(r_plen)) begin
                n_crc = ifpv_pkg::crc_byte(r_crc, i_data_byte);
                if (q_off < 18'd8) begin
                    n_frame = {r_frame[55:0], i_data_byte};
                end else if (q_off == 18'd8) begin
                    n_decl = i_data_byte; n_done = '0; n_sbp = '0;
                end else if (r_done < r_decl) begin
                    if (r_sbp < 3'd4) n_hold = {r_hold[23:0], i_data_byte};
                    if (r_sbp >= 3'd5) begin
                        emit_sample = (r_type == ifpv_pkg::TypeInput) && (r_plen != 16'd0);
                        n_done = r_done + 8'd1; n_sbp = '0; n_hold = '0;
                    end else begin
                        n_sbp = r_sbp + 3'd1;
                    end
                end
            end
            n_pos = r_pos + PW'(1);
        end
    end

    // Evaluate the verdict on the updated state, in check order
    always_comb begin
        inner = 18'(n_pos) - pre_len;
        need  = 18'd17 + 18'(n_decl) * 18'd6;
        if (18'(n_pos) < 18'(ifpv_pkg::HdrBytes)) st = ifpv_pkg::ST_SHORT;
        else if (!n_magic_ok) st = ifpv_pkg::ST_MAGIC;
        else if (pre_len > 18'(n_pos)) st = ifpv_pkg::ST_LENGTHS;
        else if (n_ver != i_protocol_version) st = ifpv_pkg::ST_VERSION;
        else if (n_rlen != 16'd0 && (!n_room_ok || n_rlen != 16'(i_room_length)))
            st = ifpv_pkg::ST_ROOM;
        else if ((n_crc ^ ifpv_pkg::CrcOnes) != n_exp_crc) st = ifpv_pkg::ST_CRC;
        else if (n_type != ifpv_pkg::TypeInput || n_plen == 16'd0) st = ifpv_pkg::ST_NOTIN;
        else if (inner < need) st = ifpv_pkg::ST_TRUNC;
        else st = ifpv_pkg::ST_OK;
    end

    // Build the event for the queue
    always_comb begin
        o_event = '0;
        o_event_valid = i_valid && (emit_sample || i_last_byte);
        o_event.has_sample = emit_sample;
        o_event.has_verdict = i_last_byte;
        o_event.sample.frame_number = n_frame;
        o_event.sample.sample_index = r_hold[31:16];
        o_event.sample.pressed = r_hold[15:8];
        o_event.sample.range_byte = r_hold[7:0];
        o_event.sample.sample_count = n_decl;
        o_event.verdict.item_kind = 1'b1;
        o_event.verdict.frame_number = n_frame;
        o_event.verdict.sample_count = n_decl;
        o_event.verdict.status = st;
        o_event.verdict.last = 1'b1;
    end

    // Hold state; clear after each verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && i_last_byte)) begin
            r_pos <= '0; r_hdr <= '0; r_exp_crc <= '0; r_crc <= ifpv_pkg::CrcOnes;
            r_hold <= '0; r_type <= '0; r_ver <= '0; r_rlen <= '0; r_plen <= '0;
            r_room_ok <= 1'b1; r_magic_ok <= 1'b0; r_frame <= '0; r_decl <= '0;
            r_done <= '0; r_sbp <= '0;
        end else if (i_valid) begin
            r_pos <= n_pos; r_hdr <= n_hdr; r_exp_crc <= n_exp_crc; r_crc <= n_crc;
            r_hold <= n_hold; r_type <= n_type; r_ver <= n_ver; r_rlen <= n_rlen;
            r_plen <= n_plen; r_room_ok <= n_room_ok; r_magic_ok <= n_magic_ok;
            r_frame <= n_frame; r_decl <= n_decl; r_done <= n_done; r_sbp <= n_sbp;
        end
    end

`include "input_frame_packet_validator_core_assert.svh"
    `IFPV_ASSERT_NEVER(a_pos_sat, i_clk, i_rst_n, 18'(r_pos) > 18'(MAX_PACKET_BYTES))
    `IFPV_ASSERT_NEVER(a_sbp_range, i_clk, i_rst_n, r_sbp > 3'd5)
    `IFPV_ASSERT_IMPL(a_done_le, i_clk, i_rst_n, (r_done <= r_decl) || (r_decl == 8'd0))
endmodule

[rtl/core/ifpv_back.sv]
// Back part: event queue and result serializer
module ifpv_back #(
    parameter int unsigned DEPTH = ifpv_pkg::QueueDepth
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_event_valid,
    input  ifpv_pkg::t_event i_event,
    output logic             o_space,
    output ifpv_pkg::t_result o_result,
    output logic             o_valid,
    input  logic             i_ready
);
    localparam int unsigned AW = $clog2(DEPTH);

    ifpv_pkg::t_event r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;
    logic          r_half;
    logic          push, pop, two, take;
    ifpv_pkg::t_event head;

    assign head = r_mem[r_rd];
    assign two  = head.has_sample && head.has_verdict;
    assign o_valid = r_cnt != '0;
    assign o_result = (head.has_sample && !r_half) ? head.sample : head.verdict;
    assign take = o_valid && i_ready;
    assign pop  = take && (!two || r_half);
    assign push = i_event_valid;
    // Room for one more event given the current fill
    assign o_space = r_cnt < (AW+1)'(DEPTH);

    // Store events
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_event;
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_cnt <= '0; r_half <= 1'b0;
        end else begin
            if (push) r_wr <= r_wr + AW'(1);
            if (pop) r_rd <= r_rd + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
            if (pop) r_half <= 1'b0;
            else if (take && two) r_half <= 1'b1;
        end
    end

`include "input_frame_packet_validator_core_assert.svh"
    `IFPV_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, push && !o_space)
    `IFPV_ASSERT_IMPL(a_half_two, i_clk, i_rst_n, r_half |-> (two && o_valid))
    `IFPV_ASSERT_NEVER(a_cnt_range, i_clk, i_rst_n, r_cnt > (AW+1)'(DEPTH))
endmodule

[dv/input_frame_packet_validator_core_tb.sv]
// Testbench for the input frame packet validator: directed and random packets vs. a predictor
`timescale 1ns / 1ps
module input_frame_packet_validator_core_tb;
    localparam int WatchdogLimit = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    ifpv_in_if  in_ch ();
    ifpv_out_if out_ch ();

    input_frame_packet_validator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor copy of the registers and packet state
    logic [15:0] cfg_version;
    logic [4:0]  cfg_room_len;
    logic [63:0] cfg_room_lo;
    logic [63:0] cfg_room_hi;

    int unsigned pkt_pos;
    logic [31:0] hdr_shift;
    logic [15:0] pkt_type_seen;
    logic [15:0] ver_seen;
    logic [15:0] room_fld_len;
    logic [15:0] player_fld_len;
    logic [31:0] crc_want;
    logic [31:0] crc_run;
    logic        room_match;
    logic        magic_match;
    logic [63:0] frame_acc;
    logic [7:0]  samples_declared;
    logic [7:0]  samples_seen;
    logic [2:0]  smp_byte_pos;
    logic [31:0] smp_hold;

    ifpv_pkg::t_result expected_items[$];
    int          fail_count;
    int          checked_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          long_hold;
    logic        room_status_seen;
    logic        ok_status_seen;
    logic [3:0]  last_verdict;

    // Stimulus queue of bytes for the driver
    logic [8:0]  byte_queue[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_packet_state();
        pkt_pos = 0;
        hdr_shift = '0;
        pkt_type_seen = '0;
        ver_seen = '0;
        room_fld_len = '0;
        player_fld_len = '0;
        crc_want = '0;
        crc_run = ifpv_pkg::CrcOnes;
        room_match = 1'b1;
        magic_match = 1'b0;
        frame_acc = '0;
        samples_declared = '0;
        samples_seen = '0;
        smp_byte_pos = '0;
        smp_hold = '0;
    endfunction

    function automatic logic [31:0] crc_advance(logic [31:0] c, logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            x = (x >> 1) ^ (x[0] ? ifpv_pkg::CrcPoly : 32'd0);
        end
        return x;
    endfunction

    function automatic logic [3:0] packet_status();
        int unsigned pre;
        int unsigned inner;
        pre = 16 + room_fld_len + player_fld_len;
        if (pkt_pos < 16) return ifpv_pkg::ST_SHORT;
        if (!magic_match) return ifpv_pkg::ST_MAGIC;
        if (pre > pkt_pos) return ifpv_pkg::ST_LENGTHS;
        if (ver_seen != cfg_version) return ifpv_pkg::ST_VERSION;
        if (room_fld_len != 0 && (!room_match || room_fld_len != cfg_room_len))
            return ifpv_pkg::ST_ROOM;
        if ((crc_run ^ ifpv_pkg::CrcOnes) != crc_want) return ifpv_pkg::ST_CRC;
        if (pkt_type_seen != ifpv_pkg::TypeInput || player_fld_len == 0)
            return ifpv_pkg::ST_NOTIN;
        inner = pkt_pos - pre;
        if (inner < 17 + 6 * samples_declared) return ifpv_pkg::ST_TRUNC;
        return ifpv_pkg::ST_OK;
    endfunction

    // Advance the predictor by one byte and queue the results it causes
    function automatic void predict_byte(logic [7:0] b, logic lastb);
        ifpv_pkg::t_result r;
        int unsigned rr;
        int unsigned q;
        logic [7:0] cfg_b;
        if (pkt_pos < ifpv_pkg::MaxPacketBytes) begin
            if (pkt_pos < 16) begin
                hdr_shift = {hdr_shift[23:0], b};
                case (pkt_pos)
                    3:  magic_match = (hdr_shift == ifpv_pkg::PktMagic);
                    5:  ver_seen = hdr_shift[15:0];
                    7:  pkt_type_seen = hdr_shift[15:0];
                    9:  room_fld_len = hdr_shift[15:0];
                    11: player_fld_len = hdr_shift[15:0];
                    15: crc_want = hdr_shift;
                    default: ;
                endcase
            end else begin
                rr = pkt_pos - 16;
                if (rr < room_fld_len) begin
                    cfg_b = (rr < 8) ? cfg_room_lo[8*(rr%8) +: 8] : cfg_room_hi[8*(rr%8) +: 8];
                    if (!(rr < cfg_room_len && rr < 16 && b == cfg_b)) room_match = 1'b0;
                end else if (rr >= room_fld_len + player_fld_len) begin
                    q = rr - room_fld_len - player_fld_len;
                    crc_run = crc_advance(crc_run, b);
                    if (q < 8) begin
                        frame_acc = {frame_acc[55:0], b};
                    end else if (q == 8) begin
                        samples_declared = b;
                        samples_seen = '0;
                        smp_byte_pos = '0;
                    end else if (samples_seen < samples_declared) begin
                        if (smp_byte_pos < 4) smp_hold = {smp_hold[23:0], b};
                        if (smp_byte_pos >= 5) begin
                            if (pkt_type_seen == ifpv_pkg::TypeInput && player_fld_len != 0) begin
                                r = '0;
                                r.frame_number = frame_acc;
                                r.sample_index = smp_hold[31:16];
                                r.pressed = smp_hold[15:8];
                                r.range_byte = smp_hold[7:0];
                                r.sample_count = samples_declared;
                                expected_items.insert(expected_items.size(), r);
                            end
                            samples_seen++;
                            smp_byte_pos = '0;
                            smp_hold = '0;
                        end else begin
                            smp_byte_pos++;
                        end
                    end
                end
            end
            pkt_pos++;
        end
        if (lastb) begin
            r = '0;
            r.item_kind = 1'b1;
            r.frame_number = frame_acc;
            r.sample_count = samples_declared;
            r.status = packet_status();
            r.last = 1'b1;
            if (r.status == ifpv_pkg::ST_ROOM) room_status_seen = 1'b1;
            if (r.status == ifpv_pkg::ST_OK) ok_status_seen = 1'b1;
            expected_items.insert(expected_items.size(), r);
            clear_packet_state();
        end
    endfunction

    // Sender: offer bytes from the queue, idle at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_byte(in_ch.data_byte, in_ch.last_byte);
                void'(byte_queue.pop_front());
            end
            // Hold a waiting byte; otherwise offer the next one or idle
            if (!in_ch.valid || in_ch.ready) begin
                if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_ch.valid     <= 1'b1;
                    in_ch.data_byte <= byte_queue[0][7:0];
                    in_ch.last_byte <= byte_queue[0][8];
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall at random, check each transaction against the oldest expectation
    always @(posedge i_clk) begin
        ifpv_pkg::t_result got;
        ifpv_pkg::t_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.item_kind, out_ch.frame_number, out_ch.sample_index,
                        out_ch.pressed, out_ch.range_byte, out_ch.sample_count,
                        out_ch.status, out_ch.last};
                if (got.item_kind) last_verdict = got.status;
                if (expected_items.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    fail_count++;
                end else begin
                    want = expected_items.pop_front();
                    checked_count++;
                    if (got !== want) begin
                        $display("%0t: mismatch expected %h actual %h", $time, want, got);
                        fail_count++;
                    end
                end
            end
            if (long_hold > 0) begin
                out_ch.ready <= 1'b0;
                long_hold--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    int idle_cycles;
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel ||
            long_hold > 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [63:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ifpv_pkg::REG_VERSION: cfg_version = value[15:0];
            ifpv_pkg::REG_ROOMLEN: cfg_room_len = value[4:0];
            ifpv_pkg::REG_ROOMLO:  cfg_room_lo = value;
            default:               cfg_room_hi = value;
        endcase
    endtask

    task automatic drain();
        while (byte_queue.size() != 0 || expected_items.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [7:0] room_byte_at(int unsigned i);
        return (i < 8) ? cfg_room_lo[8*(i%8) +: 8] : cfg_room_hi[8*(i%8) +: 8];
    endfunction

    // Build one packet; the mode picks which fault is injected
    task automatic queue_packet(int mode, int nsamp, logic [15:0] mtype);
        logic [7:0] room[$];
        logic [7:0] player[$];
        logic [7:0] body[$];
        logic [7:0] pkt[$];
        logic [31:0] c;
        int unsigned rl;
        int unsigned pl;
        logic [63:0] fr;
        rl = (mode == 1) ? 0 : cfg_room_len;
        if (rl > 16) rl = 16;
        for (int i = 0; i < rl; i++) room = {room, room_byte_at(i)};
        if (mode == 2 && rl != 0) room[$urandom_range(rl - 1)] ^= 8'h01 << $urandom_range(7);
        pl = (mode == 3) ? 0 : $urandom_range(1, 6);
        for (int i = 0; i < pl; i++) player = {player, 8'($urandom_range(255))};
        fr = {$urandom, $urandom};
        for (int i = 7; i >= 0; i--) body = {body, fr[8*i +: 8]};
        body = {body, 8'(nsamp)};
        for (int s = 0; s < nsamp; s++)
            for (int k = 0; k < 6; k++) body = {body, 8'($urandom_range(255))};
        // Drop the trailer: with up to five more body bytes for a short payload, alone so a sample ends the packet
        if (mode != 4 && mode != 10)
            for (int i = 0; i < 8; i++) body = {body, 8'($urandom_range(255))};
        if (mode == 4) repeat ($urandom_range(0, 5)) void'(body.pop_back());
        c = ifpv_pkg::CrcOnes;
        foreach (body[i]) c = crc_advance(c, body[i]);
        c = ~c;
        if (mode == 5) c ^= 32'h1 << $urandom_range(31);
        pkt = '{8'h50, 8'h43, 8'h53, 8'h58};
        if (mode == 6) pkt[$urandom_range(3)] ^= 8'h01 << $urandom_range(7);
        pkt = {pkt, cfg_version[15:8] ^ ((mode == 7) ? 8'h80 : 8'h00), cfg_version[7:0],
               mtype[15:8], mtype[7:0], 8'(rl >> 8), rl[7:0],
               ((mode == 8) ? 8'hFF : 8'h00), pl[7:0],
               c[31:24], c[23:16], c[15:8], c[7:0]};
        pkt = {pkt, room, player, body};
        if (mode == 9) repeat ($urandom_range(1, 15)) void'(pkt.pop_back());
        foreach (pkt[i]) byte_queue.insert(byte_queue.size(), {(i == pkt.size() - 1), pkt[i]});
    endtask

    // Directed table: one row per short raw sequence
    typedef struct {
        int          len;
        logic [7:0]  fill;
        logic [3:0]  verdict;
    } t_row;
    t_row dir_rows[6] = '{
        '{1, 8'h00, ifpv_pkg::ST_SHORT},
        '{15, 8'hFF, ifpv_pkg::ST_SHORT},
        '{16, 8'h00, ifpv_pkg::ST_MAGIC},
        '{16, 8'hFF, ifpv_pkg::ST_MAGIC},
        '{20, 8'hA5, ifpv_pkg::ST_MAGIC},
        '{2, 8'h5A, ifpv_pkg::ST_SHORT}
    };

    initial begin
        int modes_left;
        int burst;
        fail_count = 0;
        checked_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        long_hold = 0;
        room_status_seen = 0;
        ok_status_seen = 0;
        last_verdict = 4'hF;
        idle_cycles = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        in_ch.valid = 0; in_ch.data_byte = '0; in_ch.last_byte = 0;
        out_ch.ready = 0;
        cfg_version = 16'd0; cfg_room_len = 5'd3;
        cfg_room_lo = 64'h4E414C; cfg_room_hi = '0;
        clear_packet_state();
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: raw rows checked against the typed verdict
        foreach (dir_rows[r]) begin
            for (int i = 0; i < dir_rows[r].len; i++)
                byte_queue.insert(byte_queue.size(),
                                  {(i == dir_rows[r].len - 1), dir_rows[r].fill});
            drain();
            if (last_verdict !== dir_rows[r].verdict) begin
                $display("%0t: row %0d expected status %0d actual %0d", $time, r,
                         dir_rows[r].verdict, last_verdict);
                fail_count++;
            end
        end

        // Directed packets at reset settings
        queue_packet(0, 2, ifpv_pkg::TypeInput);
        for (int m = 1; m <= 9; m++) queue_packet(m, 0, ifpv_pkg::TypeInput);
        queue_packet(10, 2, ifpv_pkg::TypeInput);
        queue_packet(0, 0, 16'h0002);
        drain();

        // Configuration sweep with random traffic in each idle/stall phase
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            write_reg(ifpv_pkg::REG_VERSION, (ph == 1) ? 64'hFFFF :
                                             (ph == 0) ? 64'h0 : 64'($urandom));
            write_reg(ifpv_pkg::REG_ROOMLEN, (ph == 0) ? 64'd0 : (ph == 1) ? 64'd1 :
                                             (ph == 2) ? 64'd16 : 64'd31);
            write_reg(ifpv_pkg::REG_ROOMLO, (ph == 3) ? '1 : {$urandom, $urandom});
            write_reg(ifpv_pkg::REG_ROOMHI, {$urandom, $urandom});
            modes_left = 2;
            if (ph == 2) begin
                // Hold the receiver off while the sender keeps pushing
                long_hold = 400;
                queue_packet(0, 8, ifpv_pkg::TypeInput);
                modes_left = 1;
            end
            while (modes_left > 0) begin
                burst = $urandom_range(99);
                queue_packet((burst < 65) ? 0 : $urandom_range(1, 10),
                             $urandom_range(0, 4),
                             ($urandom_range(9) == 0) ? 16'($urandom) : ifpv_pkg::TypeInput);
                modes_left--;
            end
            drain();
        end

        $display("Checked %0d results over short raw sequences, fault-injected and random",
                 checked_count);
        $display("packets in four idle/stall phases; room reject seen %0d, pass seen %0d.",
                 room_status_seen, ok_status_seen);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
